@@ sv/stt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer table package
// Shared codes, state type and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package stt_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_TICK   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EXPIRED   = 3'd4,
        ST_NONE      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_WALK   = 2'd1,
        S_FINISH = 2'd2
    } state_t;

    typedef struct packed {
        logic start;
        logic walk;
        logic finish;
    } stt_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_free;
    } stt_stat_t;

endpackage

@@ sv/stt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer table controller
// Accepts one request word at a time, runs the table walk in the datapath and
// then hands the closing result to the output register.
// ----------------------------------------------------------------------------
module stt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          in_action,
    output stt_pkg::stt_cmd_t   cmd,
    input  stt_pkg::stt_stat_t  stat
);
    import stt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   action_ok;

    assign action_ok = (action_t'(in_action) == ACT_INSERT) ||
                       (action_t'(in_action) == ACT_DELETE) ||
                       (action_t'(in_action) == ACT_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && action_ok) begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (stat.walk_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.start  = 1'b0;
        cmd.walk   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid && action_ok;
            end
            S_WALK: begin
                cmd.walk = 1'b1;
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/stt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer table datapath
// Holds the timer memory, walks it one entry per cycle unless a tick stalls:
// backward to open a slot on insert, forward to close the gap on delete/tick.
// ----------------------------------------------------------------------------
module stt_datapath #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  stt_pkg::stt_cmd_t   cmd,
    output stt_pkg::stt_stat_t  stat,
    input  logic [1:0]          in_action,
    input  logic [15:0]         in_id,
    input  logic [15:0]         in_dur,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [2:0]          out_status,
    output logic [15:0]         out_id,
    output logic [4:0]          out_count,
    output logic                out_last
);
    import stt_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int EL_W  = TIME_BITS + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [ID_BITS-1:0]   mem_id  [DEPTH];
    logic [TIME_BITS-1:0] mem_dur [DEPTH];
    logic [EL_W-1:0]      mem_el  [DEPTH];

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ID_BITS-1:0]   mem_wid;
    logic [TIME_BITS-1:0] mem_wdur;
    logic [EL_W-1:0]      mem_wel;
    logic                 rd_en;
    logic [ID_BITS-1:0]   rd_id_q;
    logic [TIME_BITS-1:0] rd_dur_q;
    logic [EL_W-1:0]      rd_el_q;

    action_t              op_reg, op_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [TIME_BITS-1:0] dur_reg, dur_next;
    logic                 full_reg, full_next;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [CNT_W-1:0]     iss_left_reg, iss_left_next;
    logic [IDX_W-1:0]     iss_addr_reg, iss_addr_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]     ev_idx_reg, ev_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     keep_reg, keep_next;
    logic [CNT_W-1:0]     live_reg, live_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ID_BITS-1:0]   pend_id_reg, pend_id_next;
    logic [CNT_W-1:0]     pend_cnt_reg, pend_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [ID_BITS-1:0]   m_id_reg, m_id_next;
    logic [CNT_W-1:0]     m_cnt_reg, m_cnt_next;
    logic                 m_last_reg, m_last_next;

    logic [ID_BITS+15:0]   id_wide;
    logic [TIME_BITS+15:0] dur_wide;
    logic [ID_BITS-1:0]    id_in;
    logic [TIME_BITS-1:0]  dur_in;
    logic [ID_BITS+15:0]   oid_wide;
    logic [CNT_W+4:0]      ocnt_wide;

    logic                 out_free;
    logic [EL_W-1:0]      el_inc;
    logic                 expired;
    logic                 ins_placed;
    logic                 evaluating;
    logic                 stall;
    logic                 advance;
    logic                 eval_en;
    logic                 fin_fire;
    logic                 emit;
    status_t              e_status;
    logic [ID_BITS-1:0]   e_id;
    logic [CNT_W-1:0]     e_cnt;
    logic                 e_last;

    assign id_wide  = {{ID_BITS{1'b0}}, in_id};
    assign dur_wide = {{TIME_BITS{1'b0}}, in_dur};
    assign id_in    = id_wide[ID_BITS-1:0];
    assign dur_in   = dur_wide[TIME_BITS-1:0];

    assign out_free   = !m_valid_reg || out_ready;
    assign el_inc     = (&rd_el_q) ? rd_el_q : rd_el_q + 1'b1;
    assign expired    = el_inc > {1'b0, rd_dur_q};
    assign ins_placed = (op_reg == ACT_INSERT) && found_reg;
    assign evaluating = cmd.walk && rd_valid_reg && !ins_placed;
    assign stall      = evaluating && (op_reg == ACT_TICK) && expired &&
                        pend_valid_reg && !out_free;
    assign advance    = cmd.walk && !stall;
    assign eval_en    = evaluating && !stall;
    assign rd_en      = advance && (iss_left_reg != '0);
    assign fin_fire   = cmd.finish && out_free;

    assign stat.walk_done = ins_placed || ((iss_left_reg == '0) && !rd_valid_reg);
    assign stat.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_id[mem_waddr]  <= mem_wid;
            mem_dur[mem_waddr] <= mem_wdur;
            mem_el[mem_waddr]  <= mem_wel;
        end
        if (rd_en) begin
            rd_id_q  <= mem_id[iss_addr_reg];
            rd_dur_q <= mem_dur[iss_addr_reg];
            rd_el_q  <= mem_el[iss_addr_reg];
        end
    end

    always_comb begin
        op_next         = op_reg;
        id_next         = id_reg;
        dur_next        = dur_reg;
        full_next       = full_reg;
        held_next       = held_reg;
        iss_left_next   = iss_left_reg;
        iss_addr_next   = iss_addr_reg;
        rd_valid_next   = rd_valid_reg;
        ev_idx_next     = ev_idx_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        keep_next       = keep_reg;
        live_next       = live_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_cnt_next   = pend_cnt_reg;
        mem_we          = 1'b0;
        mem_waddr       = ev_idx_reg;
        mem_wid         = rd_id_q;
        mem_wdur        = rd_dur_q;
        mem_wel         = rd_el_q;
        emit            = 1'b0;
        e_status        = ST_NONE;
        e_id            = '0;
        e_cnt           = held_reg;
        e_last          = 1'b1;

        if (cmd.start) begin
            op_next         = action_t'(in_action);
            id_next         = id_in;
            dur_next        = dur_in;
            full_next       = (held_reg == DEPTH_CNT);
            rd_valid_next   = 1'b0;
            found_next      = 1'b0;
            pos_next        = '0;
            keep_next       = '0;
            live_next       = held_reg;
            pend_valid_next = 1'b0;
            if (action_t'(in_action) == ACT_INSERT) begin
                iss_left_next = (held_reg == DEPTH_CNT) ? '0 : held_reg;
                iss_addr_next = held_reg[IDX_W-1:0] - 1'b1;
            end else begin
                iss_left_next = held_reg;
                iss_addr_next = '0;
            end
        end

        if (advance) begin
            rd_valid_next = rd_en;
            if (rd_en) begin
                iss_left_next = iss_left_reg - 1'b1;
                ev_idx_next   = iss_addr_reg;
                if (op_reg == ACT_INSERT) begin
                    iss_addr_next = iss_addr_reg - 1'b1;
                end else begin
                    iss_addr_next = iss_addr_reg + 1'b1;
                end
            end
        end

        if (eval_en) begin
            case (op_reg)
                ACT_INSERT: begin
                    if (rd_dur_q >= dur_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = ev_idx_reg + 1'b1;
                    end else begin
                        found_next = 1'b1;
                        pos_next   = ev_idx_reg + 1'b1;
                    end
                end
                ACT_DELETE: begin
                    if (!found_reg && (rd_id_q == id_reg)) begin
                        found_next = 1'b1;
                    end else if (found_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = ev_idx_reg - 1'b1;
                    end
                end
                ACT_TICK: begin
                    if (expired) begin
                        live_next       = live_reg - 1'b1;
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_id_q;
                        pend_cnt_next   = live_reg - 1'b1;
                        if (pend_valid_reg) begin
                            emit     = 1'b1;
                            e_status = ST_EXPIRED;
                            e_id     = pend_id_reg;
                            e_cnt    = pend_cnt_reg;
                            e_last   = 1'b0;
                        end
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = keep_reg[IDX_W-1:0];
                        mem_wel   = el_inc;
                        keep_next = keep_reg + 1'b1;
                    end
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end

        if (fin_fire) begin
            emit = 1'b1;
            case (op_reg)
                ACT_INSERT: begin
                    if (full_reg) begin
                        e_status = ST_FULL;
                    end else begin
                        e_status  = ST_INSERTED;
                        e_id      = id_reg;
                        e_cnt     = held_reg + 1'b1;
                        held_next = held_reg + 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = pos_reg;
                        mem_wid   = id_reg;
                        mem_wdur  = dur_reg;
                        mem_wel   = '0;
                    end
                end
                ACT_DELETE: begin
                    if (found_reg) begin
                        e_status  = ST_DELETED;
                        e_id      = id_reg;
                        e_cnt     = held_reg - 1'b1;
                        held_next = held_reg - 1'b1;
                    end else begin
                        e_status = ST_NOT_FOUND;
                    end
                end
                ACT_TICK: begin
                    held_next = keep_reg;
                    if (pend_valid_reg) begin
                        e_status = ST_EXPIRED;
                        e_id     = pend_id_reg;
                        e_cnt    = pend_cnt_reg;
                    end else begin
                        e_status = ST_NONE;
                        e_cnt    = keep_reg;
                    end
                end
                default: begin
                    e_status = ST_NONE;
                end
            endcase
        end

        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_id_next     = m_id_reg;
        m_cnt_next    = m_cnt_reg;
        m_last_next   = m_last_reg;
        if (emit) begin
            m_valid_next  = 1'b1;
            m_status_next = e_status;
            m_id_next     = e_id;
            m_cnt_next    = e_cnt;
            m_last_next   = e_last;
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg         <= ACT_TICK;
            held_reg       <= '0;
            iss_left_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            op_reg         <= op_next;
            held_reg       <= held_next;
            iss_left_reg   <= iss_left_next;
            rd_valid_reg   <= rd_valid_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        dur_reg      <= dur_next;
        full_reg     <= full_next;
        iss_addr_reg <= iss_addr_next;
        ev_idx_reg   <= ev_idx_next;
        pos_reg      <= pos_next;
        keep_reg     <= keep_next;
        live_reg     <= live_next;
        pend_id_reg  <= pend_id_next;
        pend_cnt_reg <= pend_cnt_next;
        m_status_reg <= m_status_next;
        m_id_reg     <= m_id_next;
        m_cnt_reg    <= m_cnt_next;
        m_last_reg   <= m_last_next;
    end

    assign oid_wide   = {16'b0, m_id_reg};
    assign ocnt_wide  = {5'b0, m_cnt_reg};
    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_id     = oid_wide[15:0];
    assign out_count  = ocnt_wide[4:0];
    assign out_last   = m_last_reg;

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= DEPTH_CNT)
        else $error("timer count exceeds table depth");

    a_pend_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> op_reg == ACT_TICK)
        else $error("pending expiry outside a tick");

    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> {1'b0, mem_waddr} <= held_reg)
        else $error("table write beyond the live region");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> rd_valid_reg && $stable(ev_idx_reg))
        else $error("walk moved while the output was blocked");

endmodule

@@ sv/sorted_timer_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer table
// Timers held in ascending order of duration, with insert, delete by id and
// tick requests, each answered by one or more result words.
// ----------------------------------------------------------------------------
// Usage: a request word on the s_ channel carries the action in s_tuser and the
// timer id and duration in s_tdata. Every request answers with result words on
// the m_ channel; m_tlast marks the final word for that request. A tick gives
// one word for each expired timer in table order, or a single "none expired"
// word. Unused action code 3 is taken and ignored.
// One request is handled at a time. The walk reads one table entry per cycle
// from the timer memory unless an expiring tick stalls. s_tready rises again
// as soon as the closing word sits in the output register. If the receiver
// stalls, an expiring tick halts its walk until the output register frees,
// and no word is lost. After reset the table is empty and s_tready is high
// in the next cycle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_timer_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 16,
    parameter int TIME_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // timer_id[15:0], duration[31:16]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // result_id[15:0], live_count[20:16], zero[23:21]
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);
    import stt_pkg::*;

    stt_cmd_t    cmd;
    stt_stat_t   stat;
    logic [15:0] res_id;
    logic [4:0]  res_count;

    stt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_action (s_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

    stt_datapath #(
        .DEPTH     (TABLE_DEPTH),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (s_tuser),
        .in_id      (s_tdata[15:0]),
        .in_dur     (s_tdata[31:16]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_id     (res_id),
        .out_count  (res_count),
        .out_last   (m_tlast)
    );

    assign m_tdata = {3'b000, res_count, res_id};

endmodule
